// File: rtl/core/ihss_pkg.sv
// Shared types, constants and helpers of the image header size sniffer.
package ihss_pkg;

    // File offsets and the JPEG segment pointer are this wide; both saturate.
    localparam int POSITION_BITS = 32;
    localparam int HEADER_LEN    = 24;
    localparam int SEG_HELD      = 9;
    localparam int HDR_IDX_BITS  = $clog2(HEADER_LEN);
    localparam int SEG_OFF_BITS  = $clog2(SEG_HELD);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [POSITION_BITS:0]   pos_ext_t;
    typedef logic [POSITION_BITS+1:0] pos_cmp_t;
    typedef logic [SEG_OFF_BITS-1:0]  seg_off_t;
    typedef logic [HDR_IDX_BITS-1:0]  hdr_idx_t;

    localparam pos_t POS_MAX       = '1;
    localparam pos_t SEG_START_RST = pos_t'(2);
    localparam int   SOF_SPAN      = 12;

    // Marker and signature bytes.
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_APP0 = 8'hE0;
    localparam logic [7:0] SOF_LO_A  = 8'hC0;
    localparam logic [7:0] SOF_HI_A  = 8'hC3;
    localparam logic [7:0] SOF_LO_B  = 8'hC9;
    localparam logic [7:0] SOF_HI_B  = 8'hCB;
    localparam logic [7:0] BYTE_89   = 8'h89;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_SUB  = 8'h1A;
    localparam logic [7:0] CHAR_J    = 8'h4A;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_I    = 8'h49;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_H    = 8'h48;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_R    = 8'h52;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_JPEG = 2'd1,
        FMT_GIF  = 2'd2,
        FMT_PNG  = 2'd3
    } format_t;

    typedef struct packed {
        logic        found;
        format_t     format;
        logic [31:0] width;
        logic [31:0] height;
    } result_t;

    function automatic logic is_sof(input logic [7:0] m);
        is_sof = ((m >= SOF_LO_A) && (m <= SOF_HI_A)) ||
                 ((m >= SOF_LO_B) && (m <= SOF_HI_B));
    endfunction

endpackage

// File: rtl/core/image_header_size_sniffer_top.sv
// Image header size sniffer: streams a file and reports format, width and height.
//
//   channel | dir | tdata              | tuser            | tlast
//   s_      | in  | data_byte [7:0]    | -                | last_byte
//   m_      | out | width, height      | found, format    | -
//
// One byte is taken per cycle, back to back, with no gaps between files, except while a last byte waits.
// A byte is held in the input register, then updates the byte count,
// header store and segment walker; a last byte loads the result register,
// from which the result is presented on m_.
// Only a last byte waits for the result register; other bytes never stall.
// Synchronous active-low reset returns the walker and all counts to a new file.
module image_header_size_sniffer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // width[31:0], height[63:32]
    output logic [7:0]  m_tuser    // found[0], format[2:1], zero[7:3]
);

    typedef enum logic [1:0] {
        MODE_SEEK = 2'd0,
        MODE_SOF  = 2'd1,
        MODE_DEAD = 2'd2
    } mode_t;

    localparam int PB = ihss_pkg::POSITION_BITS;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // File state.
    ihss_pkg::pos_t pos_reg, pos_next;
    ihss_pkg::pos_t start_reg, start_next;
    logic [7:0]     hdr_reg [ihss_pkg::HEADER_LEN];
    logic [7:0]     hdr_next [ihss_pkg::HEADER_LEN];
    logic [7:0]     seg_reg [ihss_pkg::SEG_HELD];
    logic [7:0]     seg_next [ihss_pkg::SEG_HELD];
    mode_t          mode_reg, mode_next;

    // Result register.
    logic              res_valid_reg;
    ihss_pkg::result_t res_reg, res_next;

    logic               proc;
    ihss_pkg::pos_ext_t seg_diff;
    logic               in_seg;
    ihss_pkg::seg_off_t seg_off;
    logic [15:0]        seg_len;
    logic [16:0]        seg_step;
    ihss_pkg::pos_ext_t start_sum;
    ihss_pkg::pos_ext_t pos_sum;
    logic               is_jfif, is_gif, is_png, sof_fits;

    // A non-last byte never needs the result slot.
    assign proc     = in_valid_reg && (!in_last_reg || !res_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    assign seg_diff = ihss_pkg::pos_ext_t'(pos_reg) - ihss_pkg::pos_ext_t'(start_reg);
    assign in_seg   = (mode_reg != MODE_DEAD) && !seg_diff[PB] &&
                      (seg_diff[PB-1:0] < ihss_pkg::pos_t'(ihss_pkg::SEG_HELD));
    assign seg_off  = seg_diff[ihss_pkg::SEG_OFF_BITS-1:0];
    assign seg_len  = {seg_reg[2], in_data_reg};
    assign seg_step = {1'b0, seg_len} + 17'd2;
    assign start_sum = ihss_pkg::pos_ext_t'(start_reg) + ihss_pkg::pos_ext_t'(seg_step);
    assign pos_sum   = ihss_pkg::pos_ext_t'(pos_reg) + ihss_pkg::pos_ext_t'(1);

    always_comb begin
        hdr_next   = hdr_reg;
        seg_next   = seg_reg;
        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_sum[PB] ? ihss_pkg::POS_MAX : pos_sum[PB-1:0];

        if (pos_reg < ihss_pkg::pos_t'(ihss_pkg::HEADER_LEN)) begin
            hdr_next[ihss_pkg::hdr_idx_t'(pos_reg[ihss_pkg::HDR_IDX_BITS-1:0])] = in_data_reg;
        end

        if (in_seg) begin
            seg_next[seg_off] = in_data_reg;
            if (mode_reg == MODE_SEEK) begin
                if (seg_off == ihss_pkg::seg_off_t'(0)) begin
                    if (in_data_reg != ihss_pkg::BYTE_FF) begin
                        mode_next = MODE_DEAD;
                    end
                end else if (seg_off == ihss_pkg::seg_off_t'(1)) begin
                    if (ihss_pkg::is_sof(in_data_reg)) begin
                        mode_next = MODE_SOF;
                    end
                end else if (seg_off == ihss_pkg::seg_off_t'(3)) begin
                    // Skip to the next segment. A length below two makes the next
                    // segment start on bytes of this one, which are moved down.
                    start_next = start_sum[PB] ? ihss_pkg::POS_MAX : start_sum[PB-1:0];
                    for (int j = 0; j < ihss_pkg::SEG_HELD; j++) begin
                        seg_next[j] = 8'h00;
                    end
                    if (seg_len == 16'd0) begin
                        seg_next[0] = seg_reg[2];
                        seg_next[1] = in_data_reg;
                        if (seg_reg[2] != ihss_pkg::BYTE_FF) begin
                            mode_next = MODE_DEAD;
                        end else if (ihss_pkg::is_sof(in_data_reg)) begin
                            mode_next = MODE_SOF;
                        end
                    end else if (seg_len == 16'd1) begin
                        seg_next[0] = in_data_reg;
                        if (in_data_reg != ihss_pkg::BYTE_FF) begin
                            mode_next = MODE_DEAD;
                        end
                    end
                end
            end
        end
    end

    // End-of-file decision, on the state that includes the last byte.
    assign is_jfif = (hdr_next[0] == ihss_pkg::BYTE_FF) && (hdr_next[1] == ihss_pkg::BYTE_SOI) &&
                     (hdr_next[2] == ihss_pkg::BYTE_FF) && (hdr_next[3] == ihss_pkg::BYTE_APP0) &&
                     (hdr_next[6] == ihss_pkg::CHAR_J) && (hdr_next[7] == ihss_pkg::CHAR_F) &&
                     (hdr_next[8] == ihss_pkg::CHAR_I) && (hdr_next[9] == ihss_pkg::CHAR_F);
    assign is_gif  = (hdr_next[0] == ihss_pkg::CHAR_G) && (hdr_next[1] == ihss_pkg::CHAR_I) &&
                     (hdr_next[2] == ihss_pkg::CHAR_F);
    assign is_png  = (hdr_next[0] == ihss_pkg::BYTE_89) && (hdr_next[1] == ihss_pkg::CHAR_P) &&
                     (hdr_next[2] == ihss_pkg::CHAR_N) && (hdr_next[3] == ihss_pkg::CHAR_G) &&
                     (hdr_next[4] == ihss_pkg::BYTE_CR) && (hdr_next[5] == ihss_pkg::BYTE_LF) &&
                     (hdr_next[6] == ihss_pkg::BYTE_SUB) && (hdr_next[7] == ihss_pkg::BYTE_LF) &&
                     (hdr_next[12] == ihss_pkg::CHAR_I) && (hdr_next[13] == ihss_pkg::CHAR_H) &&
                     (hdr_next[14] == ihss_pkg::CHAR_D) && (hdr_next[15] == ihss_pkg::CHAR_R);
    assign sof_fits = (ihss_pkg::pos_cmp_t'(start_next) + ihss_pkg::pos_cmp_t'(ihss_pkg::SOF_SPAN))
                      <= (ihss_pkg::pos_cmp_t'(pos_reg) + ihss_pkg::pos_cmp_t'(1));

    always_comb begin
        res_next = '0;
        res_next.format = ihss_pkg::FMT_NONE;
        if (pos_reg >= ihss_pkg::pos_t'(ihss_pkg::HEADER_LEN - 1)) begin
            if (is_jfif) begin
                if ((mode_next == MODE_SOF) && sof_fits) begin
                    res_next.found  = 1'b1;
                    res_next.format = ihss_pkg::FMT_JPEG;
                    res_next.height = {16'h0000, seg_next[5], seg_next[6]};
                    res_next.width  = {16'h0000, seg_next[7], seg_next[8]};
                end
            end else if (is_gif) begin
                res_next.found  = 1'b1;
                res_next.format = ihss_pkg::FMT_GIF;
                res_next.width  = {16'h0000, hdr_next[7], hdr_next[6]};
                res_next.height = {16'h0000, hdr_next[9], hdr_next[8]};
            end else if (is_png) begin
                res_next.found  = 1'b1;
                res_next.format = ihss_pkg::FMT_PNG;
                res_next.width  = {hdr_next[16], hdr_next[17], hdr_next[18], hdr_next[19]};
                res_next.height = {hdr_next[20], hdr_next[21], hdr_next[22], hdr_next[23]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= '0;
            start_reg     <= ihss_pkg::SEG_START_RST;
            mode_reg      <= MODE_SEEK;
            for (int j = 0; j < ihss_pkg::HEADER_LEN; j++) begin
                hdr_reg[j] <= 8'h00;
            end
            for (int j = 0; j < ihss_pkg::SEG_HELD; j++) begin
                seg_reg[j] <= 8'h00;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (s_tvalid && s_tready) begin
                in_data_reg <= s_tdata;
                in_last_reg <= s_tlast;
            end

            if (proc && in_last_reg) begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end else if (m_tready) begin
                res_valid_reg <= 1'b0;
            end

            if (proc) begin
                if (in_last_reg) begin
                    // The file is done: start over for the next one.
                    pos_reg   <= '0;
                    start_reg <= ihss_pkg::SEG_START_RST;
                    mode_reg  <= MODE_SEEK;
                    for (int j = 0; j < ihss_pkg::HEADER_LEN; j++) begin
                        hdr_reg[j] <= 8'h00;
                    end
                    for (int j = 0; j < ihss_pkg::SEG_HELD; j++) begin
                        seg_reg[j] <= 8'h00;
                    end
                end else begin
                    pos_reg   <= pos_next;
                    start_reg <= start_next;
                    mode_reg  <= mode_next;
                    hdr_reg   <= hdr_next;
                    seg_reg   <= seg_next;
                end
            end
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {res_reg.height, res_reg.width};
    assign m_tuser  = {5'b00000, res_reg.format, res_reg.found};

    // A result flags found exactly when it names a format.
    a_found_format: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_reg.found == (res_reg.format != ihss_pkg::FMT_NONE)))
        else $error("found and format disagree");

    // A result that is not found carries zero dimensions.
    a_zero_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res_reg.found) |-> (m_tdata == 64'd0))
        else $error("not-found result carries dimensions");

    // The last byte of a file restarts the count and the segment walk.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_last_reg) |=>
            ((pos_reg == '0) && (mode_reg == MODE_SEEK) &&
             (start_reg == ihss_pkg::SEG_START_RST) && m_tvalid))
        else $error("file state not cleared after last beat");

    // Within a file the byte count never returns to zero.
    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && !in_last_reg) |=> (pos_reg != '0))
        else $error("byte count did not advance");

    // A broken segment chain stays broken until the file ends.
    a_dead_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == MODE_DEAD) && !(proc && in_last_reg)) |=> (mode_reg == MODE_DEAD))
        else $error("broken segment chain recovered");

endmodule
